>>> src/next_prime_finder_top_assert.svh
`ifndef NEXT_PRIME_FINDER_TOP_ASSERT_SVH
`define NEXT_PRIME_FINDER_TOP_ASSERT_SVH

// Checks that hold in the same cycle as the trigger.
`define NPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that hold in the cycle after the trigger.
`define NPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/npf_pkg.sv
package npf_pkg;

  localparam int unsigned ValueBitsDef = 16;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } npf_rem_sts_t;

endpackage

>>> src/npf_rem.sv
module npf_rem import npf_pkg::*; #(
  parameter int unsigned VALUE_BITS = ValueBitsDef,
  parameter int unsigned DIV_BITS   = (VALUE_BITS + 2) / 2 + 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [VALUE_BITS:0] dividend_i,
  input  logic [DIV_BITS-1:0] divisor_i,
  output npf_rem_sts_t        sts_o
);

  localparam int unsigned CntBits = $clog2(VALUE_BITS + 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic [VALUE_BITS:0] num_q, num_d;
  logic [DIV_BITS-1:0] den_q, den_d;
  logic [DIV_BITS-1:0] rem_q, rem_d;
  logic [DIV_BITS:0]   trial;

  // One restoring step per cycle, dividend bits taken from the top down.
  assign trial = {rem_q, num_q[VALUE_BITS]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntBits'(VALUE_BITS);
      num_d  = dividend_i;
      den_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[VALUE_BITS-1:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = DIV_BITS'(trial - {1'b0, den_q});
      end else begin
        rem_d = DIV_BITS'(trial);
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign sts_o.done     = done_q;
  assign sts_o.rem_zero = (rem_q == '0);

endmodule

>>> src/next_prime_finder_top.sv
// Channel   Direction  Fields (lowest bit up)
// s_axis    in         tdata: start_value
// m_axis    out        tdata: next_prime
//
// Each trial divisor is tested by the bit-serial remainder unit; an item works through
// all trial divisors of all candidates tried before its result is loaded.
// The input is ready only while no item is in progress; the result waits in an
// output register, and a stalled output holds the block before the result is loaded.
// Reset is asynchronous and clears all control state.
`include "next_prime_finder_top_assert.svh"

module next_prime_finder_top import npf_pkg::*; #(
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]      s_axis_tdata_i,  // start_value
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [((VALUE_BITS+8)/8)*8-1:0]      m_axis_tdata_o   // next_prime
);

  localparam int unsigned DivBits  = (VALUE_BITS + 2) / 2 + 1;
  localparam int unsigned SqBits   = 2 * DivBits;
  localparam int unsigned OutBits  = ((VALUE_BITS + 8) / 8) * 8;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [VALUE_BITS-1:0] start_q, start_d;
  logic [VALUE_BITS:0]   cand_q, cand_d;
  logic [DivBits-1:0]    d_q, d_d;
  logic [SqBits-1:0]     sq_q, sq_d;
  logic                  out_valid_q, out_valid_d;
  logic [VALUE_BITS:0]   out_q, out_d;
  logic                  in_beat;
  logic                  out_free;
  logic                  out_load;
  logic                  div_start;
  npf_rem_sts_t          rem_sts;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d     = state_q;
    start_d     = start_q;
    cand_d      = cand_q;
    d_d         = d_q;
    sq_d        = sq_q;
    out_d       = out_q;
    out_load    = 1'b0;
    div_start   = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          start_d = s_axis_tdata_i[VALUE_BITS-1:0];
          cand_d  = {1'b0, s_axis_tdata_i[VALUE_BITS-1:0]} + 1'b1;
          d_d     = DivBits'(2);
          sq_d    = SqBits'(4);
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (cand_q < (VALUE_BITS+1)'(2)) begin
          cand_d = cand_q + 1'b1;
        end else if (sq_q > SqBits'(cand_q)) begin
          if (out_free) begin
            out_load    = 1'b1;
            out_d       = cand_q;
            out_valid_d = 1'b1;
            state_d     = S_IDLE;
          end
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (rem_sts.done) begin
          if (rem_sts.rem_zero) begin
            cand_d = cand_q + 1'b1;
            d_d    = DivBits'(2);
            sq_d   = SqBits'(4);
          end else begin
            d_d  = d_q + 1'b1;
            sq_d = sq_q + SqBits'({d_q, 1'b1});
          end
          state_d = S_CHECK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    cand_q  <= cand_d;
    d_q     <= d_d;
    sq_q    <= sq_d;
    out_q   <= out_d;
  end

  npf_rem #(
    .VALUE_BITS (VALUE_BITS),
    .DIV_BITS   (DivBits)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cand_q),
    .divisor_i  (d_q),
    .sts_o      (rem_sts)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutBits'(out_q);

  `NPF_ASSERT_NEXT(a_div_returns, state_q == S_DIV, state_q == S_DIV || state_q == S_CHECK, "left division state unexpectedly")
  `NPF_ASSERT_NEXT(a_result_above_start, out_load, out_q > {1'b0, start_q}, "result not above start value")
  `NPF_ASSERT_NOW(a_divisor_min, state_q != S_IDLE, d_q >= DivBits'(2), "trial divisor below two")
  `NPF_ASSERT_NOW(a_no_load_stalled, out_load, !out_valid_q || m_axis_tready_i, "result loaded over a waiting beat")

endmodule

>>> tb/testbench.sv
module testbench;
  import npf_pkg::*;

  localparam int unsigned VB    = ValueBitsDef;
  localparam int unsigned IN_W  = ((VB + 7) / 8) * 8;
  localparam int unsigned OUT_W = ((VB + 8) / 8) * 8;

  typedef struct {
    logic [VB-1:0] value;
    bit            hold_for_drain;
  } start_req_t;

  logic             clk_i;
  logic             rst_ni;
  logic             s_valid;
  logic [IN_W-1:0]  s_data;
  logic             s_axis_tready_o;
  logic             m_axis_tvalid_o;
  logic             m_ready;
  logic [OUT_W-1:0] m_axis_tdata_o;

  start_req_t  start_q[$];
  logic [VB:0] prime_due_q[$];
  int          error_count;
  int          burst_left;
  int          gap_left;
  int          ready_run;
  bit          ready_phase;

  next_prime_finder_top #(
    .VALUE_BITS(VB)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  function automatic logic [VB:0] next_prime_after(logic [VB-1:0] start);
    longint unsigned cand;
    longint unsigned div;
    bit              is_prime;
    cand     = longint'(start) + 1;
    is_prime = 1'b0;
    while (!is_prime) begin
      is_prime = (cand >= 2);
      for (div = 2; is_prime && div * div <= cand; div++) begin
        if (cand % div == 0) begin
          is_prime = 1'b0;
        end
      end
      if (!is_prime) begin
        cand++;
      end
    end
    return cand[VB:0];
  endfunction

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  // Sender: bursts of random length, random gaps, and an occasional hold until the
  // result queue has drained.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid    <= 1'b0;
      s_data     <= '0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (s_valid && s_axis_tready_o) begin
        prime_due_q.push_back(next_prime_after(s_data[VB-1:0]));
      end
      if (!s_valid || s_axis_tready_o) begin
        if (gap_left != 0) begin
          gap_left--;
          s_valid <= 1'b0;
        end else if (start_q.size() != 0 &&
                     !(start_q[0].hold_for_drain && prime_due_q.size() != 0)) begin
          s_valid <= 1'b1;
          s_data  <= IN_W'(start_q[0].value);
          void'(start_q.pop_front());
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 8);
            gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 20);
          end else begin
            burst_left--;
          end
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: alternating runs of ready and stall of random length.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready     <= 1'b0;
      ready_run   = 0;
      ready_phase = 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_ready) begin
        if (prime_due_q.size() == 0) begin
          error_count++;
          if (error_count <= 10) begin
            $display("unexpected result beat: next_prime=%0d", m_axis_tdata_o);
          end
        end else begin
          if (m_axis_tdata_o !== OUT_W'(prime_due_q[0])) begin
            error_count++;
            if (error_count <= 10) begin
              $display("next_prime mismatch: expected %0d, got %0d",
                       prime_due_q[0], m_axis_tdata_o);
            end
          end
          void'(prime_due_q.pop_front());
        end
      end
      if (ready_run == 0) begin
        ready_phase = ~ready_phase;
        ready_run   = ready_phase ? $urandom_range(1, 30) : $urandom_range(1, 40);
      end
      ready_run--;
      m_ready <= ready_phase;
    end
  end

  initial begin
    #600_000_000;
    $display("next_prime_finder_top regression: fail");
    $finish;
  end

  initial begin
    logic [VB-1:0] directed[] = '{0, 1, 2, 3, 4, 7, 8, 24, 113, 168, 288, 1368, 31397,
                                   63000, 65520, 65521, 65534, 65535, 16'h5555,
                                   16'hAAAA, 16'h8000, 16'h7FFF};
    start_req_t    req;
    int            sel;
    error_count = 0;
    rst_ni      = 1'b0;
    foreach (directed[i]) begin
      req.value          = directed[i];
      req.hold_for_drain = 1'b0;
      start_q.push_back(req);
    end
    for (int i = 0; i < 78; i++) begin
      sel = $urandom_range(0, 19);
      if (sel < 12) begin
        req.value = VB'($urandom_range(0, 255));
      end else if (sel < 17) begin
        req.value = VB'($urandom_range(0, 4095));
      end else begin
        req.value = VB'($urandom_range(0, 65535));
      end
      req.hold_for_drain = (i == 0 || i == 50);
      start_q.push_back(req);
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (start_q.size() != 0 || s_valid) begin
      @(posedge clk_i);
    end
    while (prime_due_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (200) @(posedge clk_i);
    if (error_count == 0 && prime_due_q.size() == 0) begin
      $display("next_prime_finder_top regression: pass");
    end else begin
      $display("next_prime_finder_top regression: fail");
    end
    $finish;
  end

endmodule
